// ----- hdl/client_hello_offset_finder_core_defines.svh -----
// Assertion macros used by the ClientHello offset finder checker
`ifndef CLIENT_HELLO_OFFSET_FINDER_CORE_DEFINES_SVH
`define CLIENT_HELLO_OFFSET_FINDER_CORE_DEFINES_SVH

// clocked assertion, off while reset is high
`define CHOF_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked assertion that also holds through reset
`define CHOF_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- hdl/chof_pkg.sv -----
// Shared constants for the ClientHello offset finder
package chof_pkg;

   localparam int DEF_OFFSET_BITS = 16;
   localparam int RANDOM_BYTES    = 32;

   localparam logic [15:0] ECH_TYPE_RESET = 16'd65037;
   localparam logic [15:0] SNI_TYPE       = 16'd0;
   localparam logic [15:0] NO_ECH_TYPE    = 16'hffff;
   localparam logic [15:0] VER_TLS12      = 16'h0303;
   localparam logic [15:0] VER_TLS13      = 16'h0304;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 144;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_MALFORMED = 2'd1;
   localparam logic [1:0] STATUS_TOO_LONG  = 2'd2;

   localparam logic [3:0] PH_VER_HI    = 4'd0;
   localparam logic [3:0] PH_VER_LO    = 4'd1;
   localparam logic [3:0] PH_RANDOM    = 4'd2;
   localparam logic [3:0] PH_SID_LEN   = 4'd3;
   localparam logic [3:0] PH_SID       = 4'd4;
   localparam logic [3:0] PH_CS_HI     = 4'd5;
   localparam logic [3:0] PH_CS_LO     = 4'd6;
   localparam logic [3:0] PH_CS        = 4'd7;
   localparam logic [3:0] PH_COMP_LEN  = 4'd8;
   localparam logic [3:0] PH_COMP      = 4'd9;
   localparam logic [3:0] PH_EXTLEN_HI = 4'd10;
   localparam logic [3:0] PH_EXTLEN_LO = 4'd11;
   localparam logic [3:0] PH_EHDR      = 4'd12;
   localparam logic [3:0] PH_EBODY     = 4'd13;
   localparam logic [3:0] PH_DONE      = 4'd14;

   localparam logic [15:0] HDR_TYPE_HI = 16'd4;
   localparam logic [15:0] HDR_TYPE_LO = 16'd3;
   localparam logic [15:0] HDR_LEN_HI  = 16'd2;

endpackage

// ----- hdl/client_hello_offset_finder_core.sv -----
// ClientHello offset finder: byte-stream parser with registered result
//
// Takes one ClientHello body byte per cycle on req_ and, on the byte with
// tlast, gives one item on rsp_ with the status, the recorded offsets and
// lengths and the ECH marker. Each byte goes through an input register and
// one parse-state update; the result register loads as the last byte leaves
// the input register. One byte is accepted every cycle, also while a result
// waits on rsp_; a last byte stalls only while the result register is full
// and rsp_tready is low. The csr_ write sets the ECH extension type (reset 65037).
module client_hello_offset_finder_core #(
   parameter int OFFSET_BITS = chof_pkg::DEF_OFFSET_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [chof_pkg::REQ_DATA_W-1:0]   req_tdata,  // [7:0] data_byte
   input  logic                              req_tlast,  // last_byte
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [1:0] status, [17:2] session_id_offset, [33:18] extensions_offset,
   // [49:34] extensions_length, [65:50] ech_offset, [81:66] ech_type,
   // [97:82] ech_length, [113:98] sni_offset, [129:114] sni_length,
   // [137:130] inner_marker, [138] inner_valid, [143:139] zero
   output logic [chof_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_wen,
   input  logic [15:0]                       csr_wdata
);
   import chof_pkg::*;

   localparam logic [OFFSET_BITS-1:0] MAX_LEN = {OFFSET_BITS{1'b1}};

   logic [15:0] ech_cfg_ff;

   logic       s1_valid_ff;
   logic [7:0] s1_data_ff;
   logic       s1_last_ff;
   logic       s1_go;

   logic [3:0]             ph_ff,        ph_in;
   logic [OFFSET_BITS-1:0] pos_ff,       pos_in;
   logic [15:0]            rem_ff,       rem_in;
   logic [7:0]             hold_ff,      hold_in;
   logic [OFFSET_BITS-1:0] ext_start_ff, ext_start_in;
   logic [15:0]            cur_type_ff,  cur_type_in;
   logic [1:0]             hits_ff,      hits_in;
   logic [15:0]            sid_off_ff,   sid_off_in;
   logic [15:0]            exts_off_ff,  exts_off_in;
   logic [15:0]            exts_len_ff,  exts_len_in;
   logic [15:0]            ech_off_ff,   ech_off_in;
   logic [15:0]            ech_type_ff,  ech_type_in;
   logic [15:0]            ech_len_ff,   ech_len_in;
   logic [15:0]            sni_off_ff,   sni_off_in;
   logic [15:0]            sni_len_ff,   sni_len_in;
   logic [8:0]             mark_ff,      mark_in;
   logic [8:0]             inner_ff,     inner_in;
   logic [1:0]             err_ff,       err_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff;
   logic [RSP_DATA_W-1:0]  rsp_data_in;

   logic [7:0]             b;
   logic [15:0]            word;
   logic [OFFSET_BITS-1:0] pos_next;
   logic [OFFSET_BITS-1:0] hdr_start;
   logic [OFFSET_BITS-1:0] ext_span;
   logic                   ext_end;
   logic                   is_ech;
   logic                   is_sni;
   logic [2:0]             hits_sum;
   logic [1:0]             status;

   assign s1_go      = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_go;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign b         = s1_data_ff;
   assign word      = {hold_ff, b};
   assign pos_next  = pos_ff + OFFSET_BITS'(1);
   assign hdr_start = pos_ff - OFFSET_BITS'(3);
   assign ext_span  = pos_next - ext_start_ff;
   assign ext_end   = ext_span >= OFFSET_BITS'(exts_len_ff);
   assign is_ech    = cur_type_ff == ech_cfg_ff;
   assign is_sni    = cur_type_ff == SNI_TYPE;
   assign hits_sum  = 3'(hits_ff) + 3'(is_ech) + 3'(is_sni);

   // parse step for the byte in the input register
   always_comb begin
      ph_in        = ph_ff;
      pos_in       = pos_ff;
      rem_in       = rem_ff;
      hold_in      = hold_ff;
      ext_start_in = ext_start_ff;
      cur_type_in  = cur_type_ff;
      hits_in      = hits_ff;
      sid_off_in   = sid_off_ff;
      exts_off_in  = exts_off_ff;
      exts_len_in  = exts_len_ff;
      ech_off_in   = ech_off_ff;
      ech_type_in  = ech_type_ff;
      ech_len_in   = ech_len_ff;
      sni_off_in   = sni_off_ff;
      sni_len_in   = sni_len_ff;
      mark_in      = mark_ff;
      inner_in     = inner_ff;
      err_in       = err_ff;
      if (err_ff != 2'd0 || ph_ff == PH_DONE) begin
         ph_in = ph_ff;
      end else if (pos_ff == MAX_LEN) begin
         err_in = STATUS_TOO_LONG;
         ph_in  = PH_DONE;
      end else begin
         pos_in = pos_next;
         unique case (ph_ff)
            PH_VER_HI: begin
               hold_in = b;
               ph_in   = PH_VER_LO;
            end
            PH_VER_LO: begin
               if (word == VER_TLS12 || word == VER_TLS13) begin
                  rem_in = 16'(RANDOM_BYTES);
                  ph_in  = PH_RANDOM;
               end else begin
                  ph_in = PH_DONE;
               end
            end
            PH_RANDOM: begin
               rem_in = rem_ff - 16'd1;
               if (rem_ff == 16'd1) begin
                  sid_off_in = pos_next[15:0];
                  ph_in      = PH_SID_LEN;
               end
            end
            PH_SID_LEN: begin
               rem_in = {8'd0, b};
               ph_in  = (b == 8'd0) ? PH_CS_HI : PH_SID;
            end
            PH_SID: begin
               rem_in = rem_ff - 16'd1;
               if (rem_ff == 16'd1) ph_in = PH_CS_HI;
            end
            PH_CS_HI: begin
               hold_in = b;
               ph_in   = PH_CS_LO;
            end
            PH_CS_LO: begin
               rem_in = word;
               ph_in  = (word == 16'd0) ? PH_COMP_LEN : PH_CS;
            end
            PH_CS: begin
               rem_in = rem_ff - 16'd1;
               if (rem_ff == 16'd1) ph_in = PH_COMP_LEN;
            end
            PH_COMP_LEN: begin
               rem_in = {8'd0, b};
               if (b == 8'd0) begin
                  exts_off_in = pos_next[15:0];
                  ph_in       = PH_EXTLEN_HI;
               end else begin
                  ph_in = PH_COMP;
               end
            end
            PH_COMP: begin
               rem_in = rem_ff - 16'd1;
               if (rem_ff == 16'd1) begin
                  exts_off_in = pos_next[15:0];
                  ph_in       = PH_EXTLEN_HI;
               end
            end
            PH_EXTLEN_HI: begin
               hold_in = b;
               ph_in   = PH_EXTLEN_LO;
            end
            PH_EXTLEN_LO: begin
               exts_len_in = word;
               if (word == 16'd0) begin
                  ph_in = PH_DONE;
               end else begin
                  ext_start_in = pos_next;
                  rem_in       = HDR_TYPE_HI;
                  ph_in        = PH_EHDR;
               end
            end
            PH_EHDR: begin
               unique case (rem_ff)
                  HDR_TYPE_HI: begin
                     cur_type_in = {b, 8'd0};
                     rem_in      = rem_ff - 16'd1;
                  end
                  HDR_TYPE_LO: begin
                     cur_type_in = {cur_type_ff[15:8], b};
                     rem_in      = rem_ff - 16'd1;
                  end
                  HDR_LEN_HI: begin
                     hold_in = b;
                     rem_in  = rem_ff - 16'd1;
                  end
                  default: begin
                     if (is_ech && word == 16'd0) begin
                        err_in = STATUS_MALFORMED;
                        ph_in  = PH_DONE;
                     end else begin
                        if (is_ech) begin
                           ech_off_in  = hdr_start[15:0];
                           ech_type_in = cur_type_ff;
                           ech_len_in  = word;
                        end
                        if (is_sni) begin
                           sni_off_in = hdr_start[15:0];
                           sni_len_in = word;
                        end
                        hits_in = (hits_sum > 3'd2) ? 2'd2 : hits_sum[1:0];
                        mark_in = 9'd0;
                        if (word == 16'd0) begin
                           if (hits_in == 2'd2 || ext_end) begin
                              ph_in = PH_DONE;
                           end else begin
                              ph_in  = PH_EHDR;
                              rem_in = HDR_TYPE_HI;
                           end
                        end else begin
                           rem_in = word;
                           ph_in  = PH_EBODY;
                        end
                     end
                  end
               endcase
            end
            PH_EBODY: begin
               if (is_ech && !mark_ff[8]) mark_in = {1'b1, b};
               rem_in = rem_ff - 16'd1;
               if (rem_ff == 16'd1) begin
                  if (is_ech && mark_in[8]) inner_in = mark_in;
                  if (hits_ff == 2'd2 || ext_end) begin
                     ph_in = PH_DONE;
                  end else begin
                     ph_in  = PH_EHDR;
                     rem_in = HDR_TYPE_HI;
                  end
               end
            end
            default: begin
               ph_in = PH_DONE;
            end
         endcase
      end
   end

   always_comb begin
      priority if (err_in == STATUS_TOO_LONG) begin
         status = STATUS_TOO_LONG;
      end else if (err_in == STATUS_MALFORMED || ph_in == PH_VER_LO) begin
         status = STATUS_MALFORMED;
      end else begin
         status = STATUS_OK;
      end
      rsp_data_in = {5'd0, inner_in[8], inner_in[8] ? inner_in[7:0] : 8'd0,
                     sni_len_in, sni_off_in, ech_len_in, ech_type_in, ech_off_in,
                     exts_len_in, exts_off_in, sid_off_in, status};
      if (s1_go && s1_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ech_cfg_ff <= ECH_TYPE_RESET;
      end else if (csr_wen) begin
         ech_cfg_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_data_ff <= req_tdata;
         s1_last_ff <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (s1_go && s1_last_ff)) begin
         ph_ff        <= PH_VER_HI;
         pos_ff       <= '0;
         rem_ff       <= '0;
         hold_ff      <= '0;
         ext_start_ff <= '0;
         cur_type_ff  <= '0;
         hits_ff      <= '0;
         sid_off_ff   <= '0;
         exts_off_ff  <= '0;
         exts_len_ff  <= '0;
         ech_off_ff   <= '0;
         ech_type_ff  <= NO_ECH_TYPE;
         ech_len_ff   <= '0;
         sni_off_ff   <= '0;
         sni_len_ff   <= '0;
         mark_ff      <= '0;
         inner_ff     <= '0;
         err_ff       <= '0;
      end else if (s1_go) begin
         ph_ff        <= ph_in;
         pos_ff       <= pos_in;
         rem_ff       <= rem_in;
         hold_ff      <= hold_in;
         ext_start_ff <= ext_start_in;
         cur_type_ff  <= cur_type_in;
         hits_ff      <= hits_in;
         sid_off_ff   <= sid_off_in;
         exts_off_ff  <= exts_off_in;
         exts_len_ff  <= exts_len_in;
         ech_off_ff   <= ech_off_in;
         ech_type_ff  <= ech_type_in;
         ech_len_ff   <= ech_len_in;
         sni_off_ff   <= sni_off_in;
         sni_len_ff   <= sni_len_in;
         mark_ff      <= mark_in;
         inner_ff     <= inner_in;
         err_ff       <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_last_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ----- hdl/chof_checker.sv -----
// Port-level checker for the ClientHello offset finder, with its bind
`include "client_hello_offset_finder_core_defines.svh"

module chof_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            req_tlast,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [chof_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import chof_pkg::*;

   `CHOF_ASSERT_RST(a_reset_idle, reset |=> (!rsp_tvalid && req_tready), "not idle after reset")
   `CHOF_ASSERT(a_rsp_hold, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)), "result item changed while stalled")
   `CHOF_ASSERT(a_rsp_from_last, $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready && req_tlast, 2), "result item without a last item two cycles before")

endmodule

bind client_hello_offset_finder_core chof_checker u_chof_checker (.*);

// ----- tb/tb_client_hello_offset_finder_core.sv -----
// Testbench for the ClientHello offset finder: byte stream in, offset report out, self-checking
module tb_client_hello_offset_finder_core;
   import chof_pkg::*;

   typedef struct packed {
      logic        inner_valid;
      logic [7:0]  inner_marker;
      logic [15:0] sni_length;
      logic [15:0] sni_offset;
      logic [15:0] ech_length;
      logic [15:0] ech_type;
      logic [15:0] ech_offset;
      logic [15:0] extensions_length;
      logic [15:0] extensions_offset;
      logic [15:0] session_id_offset;
      logic [1:0]  status;
   } hello_report_type;

   localparam logic [16:0] MAX_POS = (17'd1 << DEF_OFFSET_BITS) - 17'd1;
   localparam int STALL_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 6;
   localparam int LONG_HOLD = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_wen = 1'b0;
   logic [15:0] csr_wdata = '0;

   always #6 clock = ~clock;

   client_hello_offset_finder_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   // parser state mirrored from the accepted byte stream
   logic [15:0] ech_type_cfg;
   logic [3:0]  ph;
   logic [16:0] pos;
   logic [15:0] remain;
   logic [7:0]  held;
   logic [15:0] ext_start;
   logic [15:0] cur_type;
   int          hits;
   hello_report_type rec;
   logic [8:0]  marker_pend;
   logic [8:0]  inner_val;
   logic [1:0]  err;

   hello_report_type reports_due[$];

   logic [7:0] msg_q[$];
   logic [7:0] ext_q[$];

   int errors = 0;
   int reports_checked = 0;
   int status_seen[3] = '{0, 0, 0};
   int markers_seen = 0;
   int bytes_sent = 0;
   int type_writes = 0;
   int stuck_cycles = 0;
   bit tx_idle = 1'b1;
   bit rx_idle = 1'b1;
   int hold_cycles = 0;

   function automatic void clear_hello_state();
      ph = PH_VER_HI;
      pos = '0;
      remain = '0;
      held = '0;
      ext_start = '0;
      cur_type = '0;
      hits = 0;
      rec = '0;
      rec.ech_type = NO_ECH_TYPE;
      marker_pend = '0;
      inner_val = '0;
      err = '0;
   endfunction

   function automatic void ext_done(logic [16:0] nxt);
      if (hits >= 2 || nxt - ext_start >= rec.extensions_length) begin
         ph = PH_DONE;
      end else begin
         ph = PH_EHDR;
         remain = HDR_TYPE_HI;
      end
   endfunction

   function automatic void header_done(logic [16:0] p, logic [15:0] len);
      logic [16:0] start;
      logic is_ech;
      start = p - 17'd3;
      is_ech = (cur_type == ech_type_cfg);
      if (is_ech && len == 16'd0) begin
         err = STATUS_MALFORMED;
         ph = PH_DONE;
         return;
      end
      if (is_ech) begin
         rec.ech_offset = start[15:0];
         rec.ech_type = cur_type;
         rec.ech_length = len;
         hits++;
      end
      if (cur_type == SNI_TYPE) begin
         rec.sni_offset = start[15:0];
         rec.sni_length = len;
         hits++;
      end
      if (hits > 2) hits = 2;
      marker_pend = '0;
      if (len == 16'd0) begin
         ext_done(p + 17'd1);
      end else begin
         remain = len;
         ph = PH_EBODY;
      end
   endfunction

   function automatic void parse_hello_byte(logic [7:0] b);
      logic [16:0] p;
      logic [15:0] word;
      p = pos;
      word = {held, b};
      if (err != STATUS_OK || ph == PH_DONE) return;
      if (p >= MAX_POS) begin
         err = STATUS_TOO_LONG;
         ph = PH_DONE;
         return;
      end
      pos = p + 17'd1;
      case (ph)
         PH_VER_HI: begin
            held = b;
            ph = PH_VER_LO;
         end
         PH_VER_LO: begin
            if (word == VER_TLS12 || word == VER_TLS13) begin
               remain = 16'(RANDOM_BYTES);
               ph = PH_RANDOM;
            end else begin
               ph = PH_DONE;
            end
         end
         PH_RANDOM: begin
            remain--;
            if (remain == 16'd0) begin
               rec.session_id_offset = 16'(p + 17'd1);
               ph = PH_SID_LEN;
            end
         end
         PH_SID_LEN: begin
            remain = {8'd0, b};
            ph = (b == 8'd0) ? PH_CS_HI : PH_SID;
         end
         PH_SID: begin
            remain--;
            if (remain == 16'd0) ph = PH_CS_HI;
         end
         PH_CS_HI: begin
            held = b;
            ph = PH_CS_LO;
         end
         PH_CS_LO: begin
            remain = word;
            ph = (word == 16'd0) ? PH_COMP_LEN : PH_CS;
         end
         PH_CS: begin
            remain--;
            if (remain == 16'd0) ph = PH_COMP_LEN;
         end
         PH_COMP_LEN: begin
            remain = {8'd0, b};
            if (b == 8'd0) begin
               rec.extensions_offset = 16'(p + 17'd1);
               ph = PH_EXTLEN_HI;
            end else begin
               ph = PH_COMP;
            end
         end
         PH_COMP: begin
            remain--;
            if (remain == 16'd0) begin
               rec.extensions_offset = 16'(p + 17'd1);
               ph = PH_EXTLEN_HI;
            end
         end
         PH_EXTLEN_HI: begin
            held = b;
            ph = PH_EXTLEN_LO;
         end
         PH_EXTLEN_LO: begin
            rec.extensions_length = word;
            if (word == 16'd0) begin
               ph = PH_DONE;
            end else begin
               ext_start = 16'(p + 17'd1);
               remain = HDR_TYPE_HI;
               ph = PH_EHDR;
            end
         end
         PH_EHDR: begin
            if (remain == HDR_TYPE_HI) begin
               cur_type = {b, 8'h00};
               remain--;
            end else if (remain == HDR_TYPE_LO) begin
               cur_type[7:0] = b;
               remain--;
            end else if (remain == HDR_LEN_HI) begin
               held = b;
               remain--;
            end else begin
               header_done(p, word);
            end
         end
         PH_EBODY: begin
            if (cur_type == ech_type_cfg && !marker_pend[8]) marker_pend = {1'b1, b};
            remain--;
            if (remain == 16'd0) begin
               if (cur_type == ech_type_cfg && marker_pend[8]) inner_val = marker_pend;
               ext_done(p + 17'd1);
            end
         end
         default: ph = PH_DONE;
      endcase
   endfunction

   function automatic hello_report_type close_hello_report();
      hello_report_type r;
      r = rec;
      if (err == STATUS_TOO_LONG) r.status = STATUS_TOO_LONG;
      else if (err == STATUS_MALFORMED || ph == PH_VER_LO) r.status = STATUS_MALFORMED;
      else r.status = STATUS_OK;
      r.inner_valid = inner_val[8];
      r.inner_marker = inner_val[8] ? inner_val[7:0] : 8'd0;
      clear_hello_state();
      return r;
   endfunction

   initial begin
      ech_type_cfg = ECH_TYPE_RESET;
      clear_hello_state();
   end

   // track accepted bytes and csr writes
   always @(posedge clock) begin
      if (reset) begin
         ech_type_cfg = ECH_TYPE_RESET;
         clear_hello_state();
      end else begin
         if (csr_wen) ech_type_cfg = csr_wdata;
         if (req_tvalid && req_tready) begin
            parse_hello_byte(req_tdata);
            if (req_tlast) reports_due.push_back(close_hello_report());
         end
      end
   end

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $display("%0t %s: expected %0h, actual %0h", $time, name, want, got);
         errors++;
      end
   endfunction

   hello_report_type got_rpt, want_rpt;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_rpt = rsp_tdata[138:0];
         if (reports_due.size() == 0) begin
            $display("%0t unexpected report: expected none, actual %0h", $time, rsp_tdata);
            errors++;
         end else begin
            want_rpt = reports_due.pop_front();
            check_field("status", 16'(want_rpt.status), 16'(got_rpt.status));
            check_field("session_id_offset", want_rpt.session_id_offset,
                        got_rpt.session_id_offset);
            check_field("extensions_offset", want_rpt.extensions_offset,
                        got_rpt.extensions_offset);
            check_field("extensions_length", want_rpt.extensions_length,
                        got_rpt.extensions_length);
            check_field("ech_offset", want_rpt.ech_offset, got_rpt.ech_offset);
            check_field("ech_type", want_rpt.ech_type, got_rpt.ech_type);
            check_field("ech_length", want_rpt.ech_length, got_rpt.ech_length);
            check_field("sni_offset", want_rpt.sni_offset, got_rpt.sni_offset);
            check_field("sni_length", want_rpt.sni_length, got_rpt.sni_length);
            check_field("inner_marker", 16'(want_rpt.inner_marker),
                        16'(got_rpt.inner_marker));
            check_field("inner_valid", 16'(want_rpt.inner_valid),
                        16'(got_rpt.inner_valid));
            check_field("pad", 16'd0, 16'(rsp_tdata[RSP_DATA_W-1:139]));
            if (want_rpt.status <= STATUS_TOO_LONG) status_seen[want_rpt.status]++;
            if (want_rpt.inner_valid) markers_seen++;
         end
         reports_checked++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
         if (stuck_cycles >= STALL_LIMIT) begin
            $display("%0t no progress for %0d cycles", $time, stuck_cycles);
            $display("tb: failure");
            $finish;
         end
      end
   end

   // result receiver: random stall per item, optional long hold
   initial begin
      int stall;
      forever begin
         stall = rx_idle ? $urandom_range(0, 14) : 0;
         if (hold_cycles > 0) begin
            stall = hold_cycles;
            hold_cycles = 0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   task automatic send_byte(logic [7:0] b, bit last);
      int gap;
      gap = tx_idle ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   // keep <= 0 sends the whole message
   task automatic send_message(int keep);
      int n;
      n = (keep > 0 && keep < msg_q.size()) ? keep : msg_q.size();
      for (int i = 0; i < n; i++) send_byte(msg_q[i], i == n - 1);
   endtask

   task automatic tx_stop();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      tx_stop();
      while (reports_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_ech_type(logic [15:0] v);
      wait_drained();
      csr_wen <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_wen <= 1'b0;
      type_writes++;
   endtask

   function automatic void start_hello(logic [15:0] ver, int sid_len, int cs_len,
                                       int comp_len);
      logic [15:0] cs;
      cs = 16'(cs_len);
      msg_q.delete();
      ext_q.delete();
      msg_q.push_back(ver[15:8]);
      msg_q.push_back(ver[7:0]);
      repeat (RANDOM_BYTES) msg_q.push_back(8'($urandom));
      msg_q.push_back(sid_len[7:0]);
      repeat (sid_len) msg_q.push_back(8'($urandom));
      msg_q.push_back(cs[15:8]);
      msg_q.push_back(cs[7:0]);
      repeat (cs_len) msg_q.push_back(8'($urandom));
      msg_q.push_back(comp_len[7:0]);
      repeat (comp_len) msg_q.push_back(8'($urandom));
   endfunction

   function automatic void add_ext(logic [15:0] typ, int len);
      logic [15:0] l;
      l = 16'(len);
      ext_q.push_back(typ[15:8]);
      ext_q.push_back(typ[7:0]);
      ext_q.push_back(l[15:8]);
      ext_q.push_back(l[7:0]);
      repeat (len) ext_q.push_back(8'($urandom));
   endfunction

   // declared < 0 uses the real block size
   function automatic void close_ext(int declared);
      logic [15:0] d;
      d = 16'((declared < 0) ? ext_q.size() : declared);
      msg_q.push_back(d[15:8]);
      msg_q.push_back(d[7:0]);
      foreach (ext_q[i]) msg_q.push_back(ext_q[i]);
   endfunction

   function automatic int build_random_hello();
      logic [15:0] ver;
      int n_ext, sel, len, declared;
      if ($urandom_range(0, 9) == 0) begin
         msg_q.delete();
         repeat ($urandom_range(1, 8)) msg_q.push_back(8'($urandom));
         return 0;
      end
      if ($urandom_range(0, 7) == 0) ver = 16'($urandom);
      else ver = $urandom_range(0, 1) ? VER_TLS12 : VER_TLS13;
      start_hello(ver, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 32),
                  $urandom_range(0, 8), $urandom_range(0, 3));
      n_ext = $urandom_range(0, 4);
      for (int i = 0; i < n_ext; i++) begin
         sel = $urandom_range(0, 5);
         len = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
         if (sel < 2) add_ext(ech_type_cfg, len);
         else if (sel == 2) add_ext(SNI_TYPE, len);
         else add_ext(16'($urandom), len);
      end
      declared = -1;
      if ($urandom_range(0, 7) == 0)
         declared = $urandom_range(0, 1) ? 0 : $urandom_range(0, ext_q.size() + 8);
      close_ext(declared);
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 4)) msg_q.push_back(8'($urandom));
      return ($urandom_range(0, 4) == 0) ? $urandom_range(1, msg_q.size()) : 0;
   endfunction

   task automatic test_short_messages();
      msg_q = '{8'hff};
      send_message(0);
      msg_q = '{8'h00};
      send_message(0);
      msg_q = '{8'h03, 8'h03};
      send_message(0);
      msg_q = '{8'h03, 8'h04, 8'haa};
      send_message(0);
      msg_q = '{8'hff, 8'hff};
      send_message(0);
      msg_q = '{8'h03, 8'h02, 8'h55, 8'h00, 8'hff};
      send_message(0);
   endtask

   task automatic test_full_hello();
      start_hello(VER_TLS12, 32, 4, 1);
      add_ext(16'h0017, 0);
      add_ext(16'hffff, 3);
      add_ext(SNI_TYPE, 5);
      add_ext(ech_type_cfg, 6);
      add_ext(SNI_TYPE, 2);
      close_ext(-1);
      send_message(0);
      start_hello(VER_TLS13, 0, 0, 0);
      add_ext(ech_type_cfg, 1);
      add_ext(SNI_TYPE, 0);
      add_ext(16'h0033, 2);
      close_ext(-1);
      msg_q.push_back(8'h5a);
      send_message(0);
   endtask

   task automatic test_empty_ech();
      start_hello(VER_TLS12, 3, 2, 1);
      add_ext(SNI_TYPE, 3);
      add_ext(ech_type_cfg, 0);
      add_ext(16'h000a, 2);
      close_ext(-1);
      send_message(0);
   endtask

   task automatic test_zero_ext_length();
      start_hello(VER_TLS13, 1, 2, 0);
      close_ext(0);
      repeat (3) msg_q.push_back(8'($urandom));
      send_message(0);
   endtask

   task automatic test_truncation();
      int cuts[9] = '{1, 4, 6, 7, 10, 11, 14, 20, 45};
      start_hello(VER_TLS13, 5, 2, 1);
      add_ext(SNI_TYPE, 3);
      add_ext(ech_type_cfg, 6);
      close_ext(-1);
      foreach (cuts[i]) send_message(msg_q.size() - cuts[i]);
   endtask

   task automatic test_repeated_ech();
      start_hello(VER_TLS12, 0, 0, 0);
      add_ext(ech_type_cfg, 2);
      add_ext(16'h002b, 1);
      add_ext(ech_type_cfg, 3);
      close_ext(-1);
      send_message(0);
      send_message(msg_q.size() - 1);
   endtask

   task automatic test_ech_type_settings();
      logic [15:0] v;
      write_ech_type(16'h0000);
      start_hello(VER_TLS12, 2, 2, 1);
      add_ext(16'h0010, 2);
      add_ext(SNI_TYPE, 3);
      add_ext(16'h0005, 1);
      close_ext(-1);
      send_message(0);
      start_hello(VER_TLS13, 0, 2, 1);
      add_ext(SNI_TYPE, 0);
      close_ext(-1);
      send_message(0);
      write_ech_type(16'hffff);
      start_hello(VER_TLS13, 0, 2, 1);
      add_ext(16'hffff, 4);
      add_ext(SNI_TYPE, 1);
      close_ext(-1);
      send_message(0);
      v = 16'($urandom);
      write_ech_type(v);
      start_hello(VER_TLS12, 1, 0, 0);
      add_ext(v, 2);
      close_ext(-1);
      send_message(0);
      write_ech_type(ECH_TYPE_RESET);
   endtask

   // receiver holds off while short messages keep arriving back to back
   task automatic test_backpressure();
      wait_drained();
      tx_idle = 1'b0;
      rx_idle = 1'b0;
      hold_cycles = LONG_HOLD;
      repeat (30) begin
         msg_q.delete();
         repeat ($urandom_range(1, 3)) msg_q.push_back(8'($urandom));
         send_message(0);
      end
      wait_drained();
      tx_idle = 1'b1;
      rx_idle = 1'b1;
   endtask

   task automatic test_too_long();
      wait_drained();
      tx_idle = 1'b0;
      start_hello(VER_TLS12, 0, 0, 0);
      add_ext(SNI_TYPE, 2);
      add_ext(ech_type_cfg, 65535);
      close_ext(65535);
      send_message(int'(MAX_POS) + 1);
      send_message(int'(MAX_POS));
      wait_drained();
      tx_idle = 1'b1;
   endtask

   task automatic test_random();
      logic [15:0] settings[6];
      int start_bytes, start_reports, keep, phase;
      settings = '{ECH_TYPE_RESET, 16'h0000, 16'hffff, 16'h0001, 16'h0000, 16'h0000};
      settings[4] = 16'($urandom);
      settings[5] = 16'($urandom);
      start_bytes = bytes_sent;
      start_reports = reports_checked;
      phase = 0;
      while (bytes_sent - start_bytes < 900 || reports_checked - start_reports < 40) begin
         write_ech_type(settings[phase % 6]);
         repeat (8) begin
            tx_idle = $urandom_range(0, 3) != 0;
            rx_idle = $urandom_range(0, 3) != 0;
            keep = build_random_hello();
            send_message(keep);
         end
         phase++;
      end
      wait_drained();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_short_messages();
      test_full_hello();
      test_empty_ech();
      test_zero_ext_length();
      test_truncation();
      test_repeated_ech();
      test_ech_type_settings();
      test_backpressure();
      test_too_long();
      test_random();
      wait_drained();
      if (reports_due.size() != 0) begin
         $display("%0t leftover reports: expected 0, actual %0d", $time, reports_due.size());
         errors++;
      end
      $display("summary: %0d bytes, %0d reports (ok %0d, malformed %0d, too long %0d)",
               bytes_sent, reports_checked, status_seen[0], status_seen[1], status_seen[2]);
      $display("summary: %0d inner markers, %0d ech type writes, %0d mismatches",
               markers_seen, type_writes, errors);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ----- client_hello_offset_finder_core.f -----
+incdir+hdl
hdl/chof_pkg.sv
hdl/client_hello_offset_finder_core.sv
hdl/chof_checker.sv
tb/tb_client_hello_offset_finder_core.sv
